// ----- rtl/kdpc_pkg.sv -----
package kdpc_pkg;

    // Keys visible in the transaction fields; keys beyond read as released
    localparam int FIELD_KEYS   = 3;
    localparam int NUM_KEYS_DEF = 3;

    localparam int HOLD_W  = 8;
    localparam int VALUE_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [HOLD_W-1:0]  HOLD_MAX          = '1;
    localparam logic [7:0]         LONG_HOLD_RST     = 8'd30;
    localparam logic [7:0]         SHORT_LIMIT_RST   = 8'd40;
    localparam logic [7:0]         STEP_SIZE_RST     = 8'd5;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RST     = 16'd180;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 3'd3;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CAND = 2'd1,
        PH_HELD = 2'd2
    } phase_t;

    typedef struct packed {
        logic                  mode;
        logic [FIELD_KEYS-1:0] key_levels;
        logic [VALUE_W-1:0]    value_in;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    value_out;
        logic                  confirm;
        logic [FIELD_KEYS-1:0] short_flags;
        logic [FIELD_KEYS-1:0] long_flags;
    } out_item_t;

    // Per-key control from the top level for one transaction
    typedef struct packed {
        logic tick;
        logic released;
        logic consume;
    } key_ctrl_t;

    // Per-key flags: current long flag and the flags after this transaction
    typedef struct packed {
        logic long_pending;
        logic short_next;
        logic long_next;
    } key_stat_t;

endpackage

// ----- rtl/kdpc_key.sv -----
module kdpc_key (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  kdpc_pkg::key_ctrl_t ctrl,
    input  logic [7:0]         long_hold,
    input  logic [7:0]         short_limit,
    output kdpc_pkg::key_stat_t stat
);
    import kdpc_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic [HOLD_W-1:0] hold_inc;
    logic              long_reg;
    logic              long_next;
    logic              short_reg;
    logic              short_next;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (ctrl.tick)
        begin
            unique case (phase_reg)
                PH_CAND: phase_next = ctrl.released ? PH_IDLE : PH_HELD;
                PH_HELD: phase_next = ctrl.released ? PH_IDLE : PH_HELD;
                default: phase_next = ctrl.released ? PH_IDLE : PH_CAND;
            endcase
        end
    end

    // Hold count and flags
    always_comb
    begin
        hold_inc   = (hold_reg == HOLD_MAX) ? HOLD_MAX : hold_reg + HOLD_W'(1);
        hold_next  = hold_reg;
        long_next  = long_reg;
        short_next = short_reg;
        if (ctrl.tick && phase_reg == PH_HELD)
        begin
            if (ctrl.released)
            begin
                if (hold_reg < short_limit)
                    short_next = 1'b1;
                hold_next = '0;
            end
            else if (hold_inc > long_hold)
            begin
                long_next = 1'b1;
                hold_next = '0;
            end
            else
            begin
                hold_next = hold_inc;
            end
        end
        if (ctrl.consume)
            long_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
            long_reg  <= 1'b0;
            short_reg <= 1'b0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            long_reg  <= long_next;
            short_reg <= short_next;
        end
    end

    assign stat.long_pending = long_reg;
    assign stat.short_next   = short_next;
    assign stat.long_next    = long_next;

endmodule

// ----- rtl/key_debounce_press_classifier_core.sv -----
// Debounces up to NUM_KEYS active-low keys and classifies short and long presses.
// Each input transaction is either a tick (mode 0) that samples key_levels, or a
// poll (mode 1) that consumes one pending long flag in priority order: key 0
// raises confirm, key 1 steps value_in down (floor 0), key 2 steps it up (ceiling
// max_value). Every transaction yields exactly one result transaction. The block
// takes one transaction per clock while the skid register is empty; each result is
// registered in the result or skid register. Per-key state updates at acceptance,
// and a two-entry output buffer (result register plus skid register) lets input
// continue while the output is stalled until the skid fills; in_ready depends only
// on the skid register. The user writes cfg_we/cfg_index/cfg_data only while no
// transaction is in flight (unchecked); writes to indexes beyond 3 are dropped.
module key_debounce_press_classifier_core #(
    parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kdpc_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output kdpc_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kdpc_pkg::CFG_W-1:0]     cfg_data
);
    import kdpc_pkg::*;

    // Configuration registers
    logic [7:0]         long_hold_reg;
    logic [7:0]         short_limit_reg;
    logic [7:0]         step_size_reg;
    logic [VALUE_W-1:0] max_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg   <= LONG_HOLD_RST;
            short_limit_reg <= SHORT_LIMIT_RST;
            step_size_reg   <= STEP_SIZE_RST;
            max_value_reg   <= MAX_VALUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_HOLD:   long_hold_reg   <= cfg_data[7:0];
                CFG_SHORT_LIMIT: short_limit_reg <= cfg_data[7:0];
                CFG_STEP_SIZE:   step_size_reg   <= cfg_data[7:0];
                CFG_MAX_VALUE:   max_value_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic accept;
    logic is_tick;
    logic is_poll;

    assign accept  = in_valid && in_ready;
    assign is_tick = (in_data.mode == MODE_TICK);
    assign is_poll = (in_data.mode == MODE_POLL);

    // Per-key debouncers
    key_ctrl_t             key_ctrl [NUM_KEYS];
    key_stat_t             key_stat [NUM_KEYS];
    logic [FIELD_KEYS-1:0] long_now;
    logic [FIELD_KEYS-1:0] long_after;
    logic [FIELD_KEYS-1:0] short_after;
    logic [FIELD_KEYS-1:0] consume;

    // Consume one long flag per poll, key 0 first
    assign consume[0] = is_poll && long_now[0];
    assign consume[1] = is_poll && !long_now[0] && long_now[1];
    assign consume[2] = is_poll && !long_now[0] && !long_now[1] && long_now[2];

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        if (k < FIELD_KEYS)
        begin : g_seen
            assign key_ctrl[k].released = in_data.key_levels[k];
            assign key_ctrl[k].consume  = consume[k];
        end
        else
        begin : g_unseen
            // Keys past the field never see a press and never get consumed
            assign key_ctrl[k].released = 1'b1;
            assign key_ctrl[k].consume  = 1'b0;
        end
        assign key_ctrl[k].tick = is_tick;

        kdpc_key u_key (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (accept),
            .ctrl        (key_ctrl[k]),
            .long_hold   (long_hold_reg),
            .short_limit (short_limit_reg),
            .stat        (key_stat[k])
        );
    end

    for (genvar j = 0; j < FIELD_KEYS; j++)
    begin : g_flag
        if (j < NUM_KEYS)
        begin : g_present
            assign long_now[j]    = key_stat[j].long_pending;
            assign long_after[j]  = key_stat[j].long_next;
            assign short_after[j] = key_stat[j].short_next;
        end
        else
        begin : g_absent
            assign long_now[j]    = 1'b0;
            assign long_after[j]  = 1'b0;
            assign short_after[j] = 1'b0;
        end
    end

    // Value adjustment
    logic [VALUE_W:0]   sum_up;
    logic [VALUE_W-1:0] value_down;
    logic [VALUE_W-1:0] value_up;
    out_item_t          result;

    assign sum_up     = {1'b0, in_data.value_in} + (VALUE_W+1)'(step_size_reg);
    assign value_down = (in_data.value_in >= VALUE_W'(step_size_reg))
                      ? in_data.value_in - VALUE_W'(step_size_reg) : '0;
    assign value_up   = (sum_up <= {1'b0, max_value_reg}) ? sum_up[VALUE_W-1:0]
                                                          : max_value_reg;

    always_comb
    begin
        result.value_out   = in_data.value_in;
        result.confirm     = consume[0];
        result.short_flags = short_after;
        result.long_flags  = long_after;
        priority if (consume[1])
            result.value_out = value_down;
        else if (consume[2])
            result.value_out = value_up;
        else
            result.value_out = in_data.value_in;
    end

    // Output buffer: result register plus skid register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      out_free;

    assign out_free = out_ready || !out_valid_reg;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // Drain the skid first; input is held off while it is full
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the result register is empty");

    a_one_consume: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> $onehot0(consume))
        else $error("poll consumed more than one long flag");

    a_confirm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.confirm && out_data_reg.long_flags[0]))
        else $error("confirm reported while key 0 long flag still pending");
`endif

endmodule
